// ----- hdl/art_pkg.sv -----
// ----------------------------------------------------------------------------
// Ack range tracker package
// Shared widths, codes and structures of the received range table.
// ----------------------------------------------------------------------------
package art_pkg;

    localparam int RANGE_ENTRIES = 64;
    localparam int CNT_W         = $clog2(RANGE_ENTRIES + 1);
    localparam int PN_W          = 62;
    localparam int TIME_W        = 63;
    localparam int DELAY_W       = 32;
    localparam int HELD_W        = 7;
    localparam int IN_W          = 192;
    localparam int OUT_W         = 80;

    localparam logic [PN_W-1:0] PN_MAX = '1;

    typedef enum logic [1:0] {
        CMD_RECORD,
        CMD_QUERY,
        CMD_ACK,
        CMD_NOP
    } cmd_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_EXT_START,
        OP_MERGE,
        OP_EXT_END,
        OP_ACK,
        OP_REMOVE_GE,
        OP_RETIRE
    } cell_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_CHECK,
        ST_REC_START,
        ST_REC_MERGE,
        ST_REC_END,
        ST_HORIZON,
        ST_QUERY,
        ST_ACK_EVAL,
        ST_ACK_DEL,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              vld;
        logic              ack;
        logic [PN_W-1:0]   st;
        logic [PN_W-1:0]   en;
        logic [TIME_W-1:0] stp;
    } entry_t;

    typedef struct packed {
        cell_op_t          op;
        logic              mark_en;
        logic [PN_W-1:0]   lo;
        logic [PN_W-1:0]   hi;
        logic [TIME_W-1:0] now;
    } ctl_t;

    typedef struct packed {
        logic ge_lo;
        logic touch;
        logic gt;
        logic second;
        logic hit;
        logic match;
        logic del_cand;
        logic fst_lo;
        logic fst_hi;
    } cflags_t;

    typedef struct packed {
        logic any_touch;
        logic any_second;
        logic any_hit;
        logic any_match;
        logic any_del;
        logic any_fst_lo;
        logic any_fst_hi;
    } status_t;

endpackage

// ----- hdl/art_cell.sv -----
// ----------------------------------------------------------------------------
// Ack range tracker cell
// Holds one range of the sorted table and moves it to or from its neighbours.
// ----------------------------------------------------------------------------
module art_cell
    import art_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctl_t    ctl,
    input  entry_t  left_e,
    input  cflags_t left_f,
    input  entry_t  right_e,
    output entry_t  ent,
    output cflags_t flg
);

    entry_t entry_reg;
    entry_t entry_next;
    logic [PN_W:0] en_inc;
    logic [PN_W:0] hi_inc;
    logic          first;
    logic          last;

    always_comb
    begin
        en_inc     = {1'b0, entry_reg.en} + 1'b1;
        hi_inc     = {1'b0, ctl.hi} + 1'b1;
        flg.ge_lo  = entry_reg.vld && (en_inc >= {1'b0, ctl.lo});
        flg.touch  = flg.ge_lo && ({1'b0, entry_reg.st} <= hi_inc);
        first      = flg.touch && !left_f.touch;
        last       = !right_e.vld;
        flg.gt     = !entry_reg.vld || (entry_reg.st > ctl.lo);
        flg.second = flg.touch && left_f.touch;
        flg.hit    = entry_reg.vld && (entry_reg.st <= ctl.lo) && (ctl.lo <= entry_reg.en);
        flg.match  = entry_reg.vld && (entry_reg.st == ctl.lo);
        flg.del_cand = flg.match && !last && (entry_reg.en == ctl.hi);
        flg.fst_lo = first && (ctl.lo < entry_reg.st);
        flg.fst_hi = first && (entry_reg.en < ctl.hi);
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (flg.gt)
                begin
                    if (left_f.gt)
                    begin
                        entry_next = left_e;
                    end
                    else
                    begin
                        entry_next.vld = 1'b1;
                        entry_next.ack = 1'b0;
                        entry_next.st  = ctl.lo;
                        entry_next.en  = ctl.hi;
                        entry_next.stp = ctl.now;
                    end
                end
            end
            OP_EXT_START:
            begin
                if (flg.fst_lo)
                begin
                    entry_next.st  = ctl.lo;
                    entry_next.stp = ctl.now;
                    entry_next.ack = 1'b0;
                end
            end
            OP_MERGE:
            begin
                if (left_f.ge_lo)
                begin
                    entry_next = right_e;
                end
                else if (first)
                begin
                    entry_next.en  = right_e.en;
                    entry_next.ack = 1'b0;
                    if (right_e.stp > entry_reg.stp)
                    begin
                        entry_next.stp = right_e.stp;
                    end
                end
            end
            OP_EXT_END:
            begin
                if (flg.fst_hi)
                begin
                    entry_next.en  = ctl.hi;
                    entry_next.stp = ctl.now;
                    entry_next.ack = 1'b0;
                end
            end
            OP_ACK:
            begin
                if (flg.match)
                begin
                    if (last)
                    begin
                        if (ctl.hi < entry_reg.en)
                        begin
                            if (ctl.hi >= ctl.lo)
                            begin
                                entry_next.st = hi_inc[PN_W-1:0];
                            end
                        end
                        else
                        begin
                            entry_next.st = entry_reg.en;
                        end
                    end
                    else if ((entry_reg.en == ctl.hi) && ctl.mark_en)
                    begin
                        entry_next.ack = 1'b1;
                    end
                end
            end
            OP_REMOVE_GE:
            begin
                if (entry_reg.vld && (entry_reg.st >= ctl.lo))
                begin
                    entry_next = right_e;
                end
            end
            OP_RETIRE:
            begin
                entry_next = right_e;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign ent = entry_reg;

endmodule

// ----- hdl/art_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ack range tracker sequencer
// Steps each request through the cell row and holds count, horizon and result.
// ----------------------------------------------------------------------------
module art_ctrl
    import art_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                cfg_we,
    input  logic [DELAY_W-1:0]  cfg_wdata,
    input  status_t             stat,
    input  entry_t              head,
    output ctl_t                ctl,
    output logic [CNT_W-1:0]    occ
);

    state_t            state_reg, state_next;
    logic [PN_W-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [PN_W-1:0]   horizon_reg, horizon_next;
    logic [DELAY_W-1:0] delay_reg;
    logic dup_reg, dup_next, rcv_reg, rcv_next, full_reg, full_next;
    logic match_reg, match_next, chg_reg, chg_next;
    logic              mv_reg, mv_next;
    logic [OUT_W-1:0]  md_reg, md_next;
    logic [TIME_W-1:0] age;
    logic              retire;

    always_comb
    begin
        age    = now_reg - head.stp;
        retire = (delay_reg != '0) && (occ_reg > CNT_W'(1)) && head.ack
                 && (now_reg > head.stp) && (age > {{(TIME_W-DELAY_W){1'b0}}, delay_reg});

        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        now_next     = now_reg;
        occ_next     = occ_reg;
        horizon_next = horizon_reg;
        dup_next     = dup_reg;
        rcv_next     = rcv_reg;
        full_next    = full_reg;
        match_next   = match_reg;
        chg_next     = chg_reg;
        mv_next      = mv_reg && !m_tready;
        md_next      = md_reg;
        s_tready     = 1'b0;
        ctl.op       = OP_HOLD;
        ctl.mark_en  = (delay_reg != '0);
        ctl.lo       = lo_reg;
        ctl.hi       = hi_reg;
        ctl.now      = now_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    lo_next    = s_tdata[63:2];
                    hi_next    = s_tdata[125:64];
                    now_next   = s_tdata[188:126];
                    dup_next   = 1'b0;
                    rcv_next   = 1'b0;
                    full_next  = 1'b0;
                    match_next = 1'b0;
                    chg_next   = 1'b0;
                    unique case (cmd_t'(s_tdata[1:0]))
                        CMD_RECORD: state_next = ST_REC_CHECK;
                        CMD_QUERY:  state_next = ST_QUERY;
                        CMD_ACK:    state_next = ST_ACK_EVAL;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_REC_CHECK:
            begin
                if (lo_reg > hi_reg)
                begin
                    dup_next   = 1'b1;
                    state_next = ST_HORIZON;
                end
                else if (!stat.any_touch)
                begin
                    if (occ_reg == CNT_W'(RANGE_ENTRIES))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        ctl.op   = OP_INSERT;
                        occ_next = occ_reg + 1'b1;
                    end
                    state_next = ST_HORIZON;
                end
                else
                begin
                    state_next = ST_REC_START;
                end
            end
            ST_REC_START:
            begin
                ctl.op     = OP_EXT_START;
                chg_next   = stat.any_fst_lo;
                state_next = ST_REC_MERGE;
            end
            ST_REC_MERGE:
            begin
                if (stat.any_second)
                begin
                    ctl.op   = OP_MERGE;
                    occ_next = occ_reg - 1'b1;
                    chg_next = 1'b1;
                end
                else
                begin
                    state_next = ST_REC_END;
                end
            end
            ST_REC_END:
            begin
                ctl.op     = OP_EXT_END;
                dup_next   = !(chg_reg || stat.any_fst_hi);
                state_next = ST_HORIZON;
            end
            ST_HORIZON:
            begin
                if (retire)
                begin
                    ctl.op       = OP_RETIRE;
                    occ_next     = occ_reg - 1'b1;
                    horizon_next = (head.en == PN_MAX) ? PN_MAX : head.en + 1'b1;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_QUERY:
            begin
                rcv_next   = ((delay_reg != '0) && (lo_reg < horizon_reg)) || stat.any_hit;
                state_next = ST_RESP;
            end
            ST_ACK_EVAL:
            begin
                ctl.op     = OP_ACK;
                match_next = stat.any_match;
                if (stat.any_del && (delay_reg == '0))
                begin
                    state_next = ST_ACK_DEL;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_ACK_DEL:
            begin
                ctl.op     = OP_REMOVE_GE;
                occ_next   = occ_reg - 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {7'b0, HELD_W'(occ_reg), horizon_reg,
                                  match_reg, full_reg, rcv_reg, dup_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            horizon_reg <= '0;
            delay_reg   <= '0;
            mv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            horizon_reg <= horizon_next;
            mv_reg      <= mv_next;
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        now_reg   <= now_next;
        dup_reg   <= dup_next;
        rcv_reg   <= rcv_next;
        full_reg  <= full_next;
        match_reg <= match_next;
        chg_reg   <= chg_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign occ      = occ_reg;

endmodule

// ----- hdl/ack_range_tracker.sv -----
// ----------------------------------------------------------------------------
// Ack range tracker
// Sorted table of received packet-number ranges held in a row of cells.
// ----------------------------------------------------------------------------
// Each request is taken when the block is idle and its result is placed in an
// output register, so a new request is taken while the previous result still
// waits; if that result is still unaccepted when the next one is ready, the
// block holds in its final step. A query passes a lookup step before its
// result, an ack-of-ack an evaluation step and, when it deletes a range, a
// delete step; a no-operation request goes straight to its result. A record
// passes a check step and then inserts or is refused, or, on touching stored
// ranges, extends the start, fuses ranges and extends the end; each range
// retired by the horizon adds a step. The block returns to idle before the
// next request. The time a request takes is set by the row of cells: every
// cell compares the request against its own range in parallel, but each
// fusion or retirement moves the row by one place per cycle.
module ack_range_tracker
    import art_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // command[1:0], range_low[63:2], range_high[125:64], now[188:126], zero pad
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // duplicate[0], received[1], table_full[2], ack_matched[3],
    // horizon_now[65:4], ranges_held[72:66], zero pad
    output logic [OUT_W-1:0]    m_tdata,
    input  logic                cfg_we,
    input  logic [DELAY_W-1:0]  cfg_wdata
);

    ctl_t    ctl;
    status_t stat;
    entry_t  ents [RANGE_ENTRIES];
    cflags_t flgs [RANGE_ENTRIES];
    logic [RANGE_ENTRIES-1:0] vld_vec;
    logic [CNT_W-1:0] occ;

    // Each cell sees the entries on both sides so the row can shift either way.
    for (genvar i = 0; i < RANGE_ENTRIES; i++)
    begin : g_cell
        entry_t  left_e;
        cflags_t left_f;
        entry_t  right_e;
        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign left_f = '0;
        end
        else
        begin : g_mid
            assign left_e = ents[i-1];
            assign left_f = flgs[i-1];
        end
        if (i == RANGE_ENTRIES - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = ents[i+1];
        end
        art_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .left_e  (left_e),
            .left_f  (left_f),
            .right_e (right_e),
            .ent     (ents[i]),
            .flg     (flgs[i])
        );
        assign vld_vec[i] = ents[i].vld;
    end

    // Status summary: one OR over the row for each flag.
    always_comb
    begin
        stat = '0;
        for (int i = 0; i < RANGE_ENTRIES; i++)
        begin
            stat.any_touch  = stat.any_touch  | flgs[i].touch;
            stat.any_second = stat.any_second | flgs[i].second;
            stat.any_hit    = stat.any_hit    | flgs[i].hit;
            stat.any_match  = stat.any_match  | flgs[i].match;
            stat.any_del    = stat.any_del    | flgs[i].del_cand;
            stat.any_fst_lo = stat.any_fst_lo | flgs[i].fst_lo;
            stat.any_fst_hi = stat.any_fst_hi | flgs[i].fst_hi;
        end
    end

    art_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .head      (ents[0]),
        .ctl       (ctl),
        .occ       (occ)
    );

`ifndef SYNTHESIS
    // The stored count never exceeds the row length.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= CNT_W'(RANGE_ENTRIES))
        else $error("range count beyond table size");

    // The count matches the number of occupied cells.
    a_occ_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == 32'(occ))
        else $error("range count disagrees with occupied cells");

    // Occupied cells form an unbroken run from the head of the row.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec >> 1) & ~vld_vec) == '0)
        else $error("gap in occupied cells");
`endif

endmodule
